@@ hdl/assert_macros.svh @@
// Assertion helpers used by ars_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk while rstn is high.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge of clk outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    `ASSERT_CLK(label, clk, rstn, !(cond), msg)

`endif

@@ hdl/ars_pkg.sv @@
`default_nettype none

package ars_pkg;

    // Fixed field widths.
    localparam int OP_W     = 2;
    localparam int SYM_W    = 8;
    localparam int STATUS_W = 2;
    localparam int ECNT_W   = 11;
    localparam int LIMIT_W  = 16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_PAST_END = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_WAIT,
        S_READ_WAIT,
        S_OUT
    } ars_state_t;

    // One result word.
    typedef struct packed {
        logic [ECNT_W-1:0]   entry_count;
        logic [STATUS_W-1:0] status;
        logic                out_valid;
        logic [SYM_W-1:0]    out_symbol;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/ars_entry_ram.sv @@
`default_nettype none

module ars_entry_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 24
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [DATA_W-1:0]        wdata,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] entry_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Single port: a write or a registered read in each enabled cycle.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                entry_mem[addr] <= wdata;
            end else begin
                rdata_reg <= entry_mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/ars_core.sv @@
`default_nettype none

module ars_core
    import ars_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [LIMIT_W-1:0]               cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [OP_W-1:0]                  op,
    input  wire logic [SYM_W-1:0]                 sym,
    output logic                                  res_valid,
    input  wire logic                             res_ready,
    output result_t                               res,
    output logic                                  mem_en,
    output logic                                  mem_we,
    output logic [$clog2(STACK_DEPTH)-1:0]        mem_addr,
    output logic [SYM_W+COUNT_WIDTH-1:0]          mem_wdata,
    input  wire logic [SYM_W+COUNT_WIDTH-1:0]     mem_rdata
);

`include "assert_macros.svh"

    localparam int IDXW = $clog2(STACK_DEPTH);
    localparam int PTRW = $clog2(STACK_DEPTH + 1);
    localparam int LIMW = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    ars_state_t             state_reg, state_next;
    logic [PTRW-1:0]        stack_top_reg, stack_top_next;
    logic [PTRW-1:0]        read_entry_reg, read_entry_next;
    logic [COUNT_WIDTH-1:0] read_emitted_reg, read_emitted_next;
    logic [SYM_W-1:0]       top_sym_reg, top_sym_next;
    logic [COUNT_WIDTH-1:0] top_cnt_reg, top_cnt_next;
    logic [COUNT_WIDTH-1:0] limit_reg, limit_next;
    result_t                res_reg, res_next;

    logic [PTRW-1:0]        top_minus1;
    logic [PTRW-1:0]        top_minus2;
    logic [COUNT_WIDTH:0]   cnt_inc;
    logic [SYM_W-1:0]       rd_sym;
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic [COUNT_WIDTH-1:0] emitted_inc;
    logic                   rd_done;
    logic [LIMW-1:0]        lim_ext;
    logic [LIMW-1:0]        lim_max;

    // Clamp a written run limit into the range the counters can hold.
    always_comb begin
        lim_max = LIMW'({COUNT_WIDTH{1'b1}});
        lim_ext = LIMW'(cfg_wdata);
        if (lim_ext < LIMW'(2)) begin
            lim_ext = LIMW'(2);
        end else if (lim_ext > lim_max) begin
            lim_ext = lim_max;
        end
        limit_next = cfg_we ? lim_ext[COUNT_WIDTH-1:0] : limit_reg;
    end

    // Shared helper values.
    assign top_minus1  = stack_top_reg - PTRW'(1);
    assign top_minus2  = stack_top_reg - PTRW'(2);
    assign cnt_inc     = {1'b0, top_cnt_reg} + (COUNT_WIDTH+1)'(1);
    assign rd_sym      = (state_reg == S_READ_WAIT) ? mem_rdata[SYM_W+COUNT_WIDTH-1 -: SYM_W]
                                                    : top_sym_reg;
    assign rd_cnt      = (state_reg == S_READ_WAIT) ? mem_rdata[COUNT_WIDTH-1:0] : top_cnt_reg;
    assign emitted_inc = read_emitted_reg + COUNT_WIDTH'(1);
    assign rd_done     = (emitted_inc >= rd_cnt);

    // Sequencer: next state, stack update and memory requests.
    always_comb begin
        state_next        = state_reg;
        stack_top_next    = stack_top_reg;
        read_entry_next   = read_entry_reg;
        read_emitted_next = read_emitted_reg;
        top_sym_next      = top_sym_reg;
        top_cnt_next      = top_cnt_reg;
        res_next          = res_reg;
        mem_en            = 1'b0;
        mem_we            = 1'b0;
        mem_addr          = read_entry_reg[IDXW-1:0];
        mem_wdata         = {top_sym_reg, top_cnt_reg};

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_next   = '0;
                    state_next = S_OUT;
                    case (op)
                        OP_PUSH: begin
                            read_entry_next   = '0;
                            read_emitted_next = '0;
                            if ((stack_top_reg != '0) && (top_sym_reg == sym)) begin
                                if (cnt_inc >= {1'b0, limit_reg}) begin
                                    // Run complete: drop the top entry.
                                    stack_top_next = top_minus1;
                                    if (stack_top_reg >= PTRW'(2)) begin
                                        mem_en     = 1'b1;
                                        mem_addr   = top_minus2[IDXW-1:0];
                                        state_next = S_POP_WAIT;
                                    end
                                end else begin
                                    top_cnt_next = cnt_inc[COUNT_WIDTH-1:0];
                                end
                            end else if (stack_top_reg == PTRW'(STACK_DEPTH)) begin
                                res_next.status = STAT_FULL;
                            end else begin
                                // Spill the old top to memory and start a new run.
                                if (stack_top_reg != '0) begin
                                    mem_en   = 1'b1;
                                    mem_we   = 1'b1;
                                    mem_addr = top_minus1[IDXW-1:0];
                                end
                                top_sym_next   = sym;
                                top_cnt_next   = COUNT_WIDTH'(1);
                                stack_top_next = stack_top_reg + PTRW'(1);
                            end
                        end
                        OP_READ: begin
                            if (read_entry_reg >= stack_top_reg) begin
                                res_next.status = STAT_PAST_END;
                            end else if (read_entry_reg == top_minus1) begin
                                // The top entry lives in registers.
                                res_next.out_symbol = rd_sym;
                                res_next.out_valid  = 1'b1;
                                if (rd_done) begin
                                    read_entry_next   = read_entry_reg + PTRW'(1);
                                    read_emitted_next = '0;
                                end else begin
                                    read_emitted_next = emitted_inc;
                                end
                            end else begin
                                mem_en     = 1'b1;
                                state_next = S_READ_WAIT;
                            end
                        end
                        OP_CLEAR: begin
                            stack_top_next    = '0;
                            read_entry_next   = '0;
                            read_emitted_next = '0;
                        end
                        default: begin
                        end
                    endcase
                    res_next.entry_count = ECNT_W'(stack_top_next);
                end
            end
            S_POP_WAIT: begin
                // Entry below the old top becomes the new top.
                top_sym_next = mem_rdata[SYM_W+COUNT_WIDTH-1 -: SYM_W];
                top_cnt_next = mem_rdata[COUNT_WIDTH-1:0];
                state_next   = S_OUT;
            end
            S_READ_WAIT: begin
                res_next.out_symbol = rd_sym;
                res_next.out_valid  = 1'b1;
                if (rd_done) begin
                    read_entry_next   = read_entry_reg + PTRW'(1);
                    read_emitted_next = '0;
                end else begin
                    read_emitted_next = emitted_inc;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            stack_top_reg    <= '0;
            read_entry_reg   <= '0;
            read_emitted_reg <= '0;
            limit_reg        <= COUNT_WIDTH'(2);
        end else begin
            state_reg        <= state_next;
            stack_top_reg    <= stack_top_next;
            read_entry_reg   <= read_entry_next;
            read_emitted_reg <= read_emitted_next;
            limit_reg        <= limit_next;
        end
    end

    // Top entry and result word.
    always_ff @(posedge aclk) begin
        top_sym_reg <= top_sym_next;
        top_cnt_reg <= top_cnt_next;
        res_reg     <= res_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;

    `ASSERT_NEVER(a_top_in_range, aclk, aresetn, stack_top_reg > PTRW'(STACK_DEPTH),
        "stack top beyond depth")
    `ASSERT_CLK(a_wait_to_out, aclk, aresetn,
        (state_reg == S_READ_WAIT || state_reg == S_POP_WAIT) |=> (state_reg == S_OUT),
        "memory wait not followed by result")
    `ASSERT_CLK(a_res_held, aclk, aresetn, (res_valid && !res_ready) |=> $stable(res_reg),
        "pending result changed")
    `ASSERT_CLK(a_full_flag, aclk, aresetn,
        (res_valid && res_reg.status == STAT_FULL) |-> (stack_top_reg == PTRW'(STACK_DEPTH)),
        "full status without a full stack")

endmodule

`default_nettype wire

@@ hdl/adjacent_run_removal_stack.sv @@
`default_nettype none

// Channel   Direction  Contents
// s_*       in         tuser[1:0] operation; tdata[7:0] symbol
// m_*       out        tuser[0] out_valid; tdata[7:0] out_symbol, [9:8] status,
//                      [20:10] entry_count
// cfg_*     in         cfg_wdata run_limit, written when cfg_we is high
//
// A push, clear, unused operation or read of the top entry takes the sequencer from
// S_IDLE through S_OUT back to S_IDLE before the next word is accepted; a pop that exposes
// a stored entry, or a read of an entry below the top, first passes through S_POP_WAIT or
// S_READ_WAIT respectively, for the registered read of the entry memory. The result word
// is registered in the core and then in the output register before it shows on m_tvalid.
// aresetn clears the stack pointer and read cursor and sets the limit to 2; the entry
// memory is not cleared.
// A new word is accepted while the previous result still waits in the output register;
// the sequencer stalls only while that register is full and m_tready is low.

module adjacent_run_removal_stack
    import ars_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [LIMIT_W-1:0] cfg_wdata,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] symbol
    input  wire logic [OP_W-1:0]    s_tuser,   // [1:0] operation
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [23:0]             m_tdata,   // [7:0] out_symbol, [9:8] status,
                                               // [20:10] entry_count
    output logic                    m_tuser    // [0] out_valid
);

    localparam int IDXW = $clog2(STACK_DEPTH);
    localparam int MEMW = SYM_W + COUNT_WIDTH;

    logic            res_valid;
    logic            res_ready;
    result_t         res;
    logic            mem_en;
    logic            mem_we;
    logic [IDXW-1:0] mem_addr;
    logic [MEMW-1:0] mem_wdata;
    logic [MEMW-1:0] mem_rdata;
    logic            m_valid_reg, m_valid_next;
    result_t         m_res_reg;

    ars_core #(
        .STACK_DEPTH (STACK_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .op        (s_tuser),
        .sym       (s_tdata[SYM_W-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    ars_entry_ram #(
        .DEPTH  (STACK_DEPTH),
        .DATA_W (MEMW)
    ) u_ram (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_res_reg.entry_count, m_res_reg.status, m_res_reg.out_symbol};
    assign m_tuser  = m_res_reg.out_valid;

endmodule

`default_nettype wire

@@ bench/adjacent_run_removal_stack_test.sv @@
`timescale 1ns / 1ps

module adjacent_run_removal_stack_test;
    import ars_pkg::*;

    localparam int STACK_DEPTH = 1024;
    localparam int COUNT_WIDTH = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [LIMIT_W-1:0]  cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = '0;
    logic [OP_W-1:0]     s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [23:0]         m_tdata;
    logic                m_tuser;

    // Directed stimulus row; want is used only where typed is set.
    typedef struct {
        logic [OP_W-1:0]  op;
        logic [SYM_W-1:0] sym;
        bit               typed;
        result_t          want;
    } dir_row_t;

    dir_row_t dir_rows [25];

    // Shadow copy of the run stack and the read cursor.
    logic [SYM_W-1:0]       run_sym [STACK_DEPTH];
    logic [COUNT_WIDTH-1:0] run_cnt [STACK_DEPTH];
    int unsigned            top_ptr = 0;
    int unsigned            cur_entry = 0;
    int unsigned            cur_emitted = 0;
    logic [LIMIT_W-1:0]     limit_reg = 16'd2;

    result_t     pending_results [$];
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int unsigned words_sent = 0;
    int unsigned words_seen = 0;
    int unsigned n_pops = 0;
    int unsigned n_full = 0;
    int unsigned n_chars = 0;
    int unsigned n_past_end = 0;
    int unsigned n_settings = 0;

    adjacent_run_removal_stack #(
        .STACK_DEPTH(STACK_DEPTH),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run-length reduction of one word, updating the shadow state.
    function automatic result_t reduce_step(input logic [OP_W-1:0] op,
                                            input logic [SYM_W-1:0] sym);
        result_t     r;
        int unsigned lim;
        int unsigned next_cnt;
        r = '0;
        lim = (limit_reg < 2) ? 2 : limit_reg;
        if (lim > (1 << COUNT_WIDTH) - 1)
            lim = (1 << COUNT_WIDTH) - 1;
        case (op)
            OP_PUSH: begin
                // Any push sends the read cursor back to the bottom entry.
                cur_entry = 0;
                cur_emitted = 0;
                if (top_ptr > 0 && run_sym[top_ptr-1] == sym) begin
                    next_cnt = run_cnt[top_ptr-1] + 1;
                    if (next_cnt >= lim) begin
                        top_ptr--;
                        n_pops++;
                    end else begin
                        run_cnt[top_ptr-1] = next_cnt[COUNT_WIDTH-1:0];
                    end
                end else if (top_ptr >= STACK_DEPTH) begin
                    r.status = STAT_FULL;
                    n_full++;
                end else begin
                    run_sym[top_ptr] = sym;
                    run_cnt[top_ptr] = 1;
                    top_ptr++;
                end
            end
            OP_READ: begin
                if (cur_entry >= top_ptr) begin
                    r.status = STAT_PAST_END;
                    n_past_end++;
                end else begin
                    r.out_symbol = run_sym[cur_entry];
                    r.out_valid = 1'b1;
                    n_chars++;
                    cur_emitted++;
                    if (cur_emitted >= run_cnt[cur_entry]) begin
                        cur_entry++;
                        cur_emitted = 0;
                    end
                end
            end
            OP_CLEAR: begin
                top_ptr = 0;
                cur_entry = 0;
                cur_emitted = 0;
            end
            default: begin
            end
        endcase
        r.entry_count = top_ptr[ECNT_W-1:0];
        return r;
    endfunction

    // Offer one word, wait for it to be taken, then record what should come back.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                             input bit typed, input result_t typed_result);
        result_t predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= sym;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = reduce_step(op, sym);
        if (typed)
            predicted = typed_result;
        pending_results = {pending_results, predicted};
        words_sent++;
    endtask

    // Hold the sender off until every outstanding result has been taken.
    task automatic settle;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        limit_reg = value;
        n_settings++;
    endtask

    // Mostly runs from a small alphabet so that entries grow and pop, with
    // bursts of reads, the odd clear and some noise words.
    task automatic random_traffic(input int unsigned n_words, input int unsigned max_run);
        logic [SYM_W-1:0] alphabet [4];
        int unsigned      alpha_n;
        int unsigned      sent;
        int unsigned      len;
        int unsigned      pick;
        logic [SYM_W-1:0] sym;
        result_t          none;
        none = '0;
        sent = 0;
        alpha_n = $urandom_range(1, 4);
        foreach (alphabet[k])
            alphabet[k] = SYM_W'($urandom_range(255));
        while (sent < n_words) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                len = $urandom_range(1, max_run);
                sym = alphabet[$urandom_range(alpha_n - 1)];
                repeat (len) send_word(OP_PUSH, sym, 1'b0, none);
            end else if (pick < 88) begin
                len = $urandom_range(1, 24);
                repeat (len) send_word(OP_READ, SYM_W'($urandom_range(255)), 1'b0, none);
            end else if (pick < 93) begin
                len = 1;
                send_word(OP_CLEAR, SYM_W'($urandom_range(255)), 1'b0, none);
                alpha_n = $urandom_range(1, 4);
                foreach (alphabet[k])
                    alphabet[k] = SYM_W'($urandom_range(255));
            end else begin
                len = 1;
                send_word(OP_W'($urandom_range(3)), SYM_W'($urandom_range(255)), 1'b0, none);
            end
            sent += len;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch on word %0d: %s is %0h, should be %0h", words_seen, what, got, want);
        mismatches++;
    endtask

    // Receiver stalls at random.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Compare every returned word with the oldest outstanding prediction.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unrequested word", m_tdata[15:0], 16'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] !== want.out_symbol)
                    report_mismatch("out_symbol", 16'(m_tdata[7:0]), 16'(want.out_symbol));
                if (m_tuser !== want.out_valid)
                    report_mismatch("out_valid", 16'(m_tuser), 16'(want.out_valid));
                if (m_tdata[9:8] !== want.status)
                    report_mismatch("status", 16'(m_tdata[9:8]), 16'(want.status));
                if (m_tdata[20:10] !== want.entry_count)
                    report_mismatch("entry_count", 16'(m_tdata[20:10]),
                                    16'(want.entry_count));
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        result_t none;
        none = '0;
        // Reset state, extremes of the symbol, pops, read past the end,
        // push while reading, clear and the unused operation.
        dir_rows = '{
            '{OP_READ,  8'h00, 1'b1, '{11'd0, STAT_PAST_END, 1'b0, 8'h00}},
            '{OP_SPARE, 8'ha5, 1'b1, '{11'd0, STAT_OK,       1'b0, 8'h00}},
            '{OP_PUSH,  8'h00, 1'b1, '{11'd1, STAT_OK,       1'b0, 8'h00}},
            '{OP_PUSH,  8'hff, 1'b1, '{11'd2, STAT_OK,       1'b0, 8'h00}},
            '{OP_READ,  8'h00, 1'b1, '{11'd2, STAT_OK,       1'b1, 8'h00}},
            '{OP_READ,  8'h00, 1'b1, '{11'd2, STAT_OK,       1'b1, 8'hff}},
            '{OP_READ,  8'h00, 1'b1, '{11'd2, STAT_PAST_END, 1'b0, 8'h00}},
            '{OP_PUSH,  8'hff, 1'b1, '{11'd1, STAT_OK,       1'b0, 8'h00}},
            '{OP_PUSH,  8'h00, 1'b1, '{11'd0, STAT_OK,       1'b0, 8'h00}},
            '{OP_PUSH,  8'h61, 1'b1, '{11'd1, STAT_OK,       1'b0, 8'h00}},
            '{OP_PUSH,  8'h62, 1'b0, '{11'd0, STAT_OK,       1'b0, 8'h00}},
            '{OP_READ,  8'h00, 1'b0, '{11'd0, STAT_OK,       1'b0, 8'h00}},
            '{OP_PUSH,  8'h63, 1'b0, '{11'd0, STAT_OK,       1'b0, 8'h00}},
            '{OP_READ,  8'h00, 1'b0, '{11'd0, STAT_OK,       1'b0, 8'h00}},
            '{OP_READ,  8'h00, 1'b0, '{11'd0, STAT_OK,       1'b0, 8'h00}},
            '{OP_CLEAR, 8'h00, 1'b1, '{11'd0, STAT_OK,       1'b0, 8'h00}},
            '{OP_READ,  8'h00, 1'b1, '{11'd0, STAT_PAST_END, 1'b0, 8'h00}},
            '{OP_PUSH,  8'h55, 1'b1, '{11'd1, STAT_OK,       1'b0, 8'h00}},
            '{OP_PUSH,  8'haa, 1'b1, '{11'd2, STAT_OK,       1'b0, 8'h00}},
            '{OP_PUSH,  8'haa, 1'b1, '{11'd1, STAT_OK,       1'b0, 8'h00}},
            '{OP_PUSH,  8'h55, 1'b1, '{11'd0, STAT_OK,       1'b0, 8'h00}},
            '{OP_SPARE, 8'h00, 1'b1, '{11'd0, STAT_OK,       1'b0, 8'h00}},
            '{OP_PUSH,  8'h80, 1'b1, '{11'd1, STAT_OK,       1'b0, 8'h00}},
            '{OP_PUSH,  8'h7f, 1'b1, '{11'd2, STAT_OK,       1'b0, 8'h00}},
            '{OP_CLEAR, 8'hff, 1'b1, '{11'd0, STAT_OK,       1'b0, 8'h00}}
        };

        src_idle_pct = 33;
        snk_idle_pct = 60;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].op, dir_rows[i].sym, dir_rows[i].typed, dir_rows[i].want);
        random_traffic(110, 3);

        // A limit below two behaves as two.
        write_limit(16'd0);
        random_traffic(50, 3);

        write_limit(16'd3);
        src_idle_pct = 60;
        snk_idle_pct = 33;
        random_traffic(90, 4);
        write_limit(16'd1);
        random_traffic(40, 3);
        write_limit(16'hffff);
        random_traffic(70, 8);

        // Fill the stack with alternating symbols, then push into it while full.
        write_limit(16'd3);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_word(OP_CLEAR, 8'h00, 1'b0, none);
        for (int i = 0; i < STACK_DEPTH; i++)
            send_word(OP_PUSH, (i % 2 != 0) ? 8'h5a : 8'ha5, 1'b0, none);
        send_word(OP_PUSH, 8'h3c, 1'b0, none);
        send_word(OP_PUSH, 8'h5a, 1'b0, none);
        send_word(OP_READ, 8'h00, 1'b0, none);
        send_word(OP_READ, 8'h00, 1'b0, none);
        send_word(OP_PUSH, 8'h3c, 1'b0, none);
        send_word(OP_READ, 8'h00, 1'b0, none);
        send_word(OP_PUSH, 8'h5a, 1'b0, none);
        send_word(OP_PUSH, 8'h3c, 1'b0, none);
        send_word(OP_PUSH, 8'h3c, 1'b0, none);
        send_word(OP_PUSH, 8'ha5, 1'b0, none);
        random_traffic(20, 4);

        write_limit(16'd4);
        random_traffic(60, 5);
        write_limit(16'd7);
        random_traffic(60, 9);
        settle();

        $display("%0d words over %0d limit settings: %0d pops, %0d dropped pushes",
                 words_sent, n_settings, n_pops, n_full);
        $display("%0d characters read back, %0d reads past the end", n_chars, n_past_end);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
